@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the DMA register block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, active during reset too
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dmac_pkg.sv @@
// ---------------------------------------------------------------------------
// dmac_pkg
// Types, constants and register layouts of the DMA channel register block.
// ---------------------------------------------------------------------------
`default_nettype none

package dmac_pkg;

  localparam int NumCh = 7;
  localparam int ChW = 3;

  localparam logic [31:0] DmaBase  = 32'h1F80_1000;
  localparam logic [31:0] DpcrAddr = 32'h1F80_10F0;
  localparam logic [31:0] DicrAddr = 32'h1F80_10F4;
  localparam logic [7:0]  ChSelFirst = 8'h08;
  localparam logic [7:0]  ChSelLast  = 8'h0E;
  localparam logic [3:0]  OffMadr = 4'h0;
  localparam logic [3:0]  OffBcr  = 4'h4;
  localparam logic [3:0]  OffChcr = 4'h8;
  localparam logic [23:0] AddrMask = 24'hFF_FFFC;
  localparam logic [NumCh-1:0] SupportedCh = 7'b101_1100;

  localparam int InTdataW  = 72;
  localparam int OutTdataW = 104;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_DRQ      = 2'd2,
    KIND_XFER_END = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_ERR,
    OP_RD_CHCR,
    OP_WR_MADR,
    OP_WR_BCR,
    OP_WR_CHCR,
    OP_RD_DPCR,
    OP_WR_DPCR,
    OP_RD_DICR,
    OP_WR_DICR,
    OP_DRQ,
    OP_XFER_END
  } op_t;

  typedef enum logic [1:0] {
    MODE_BURST  = 2'd0,
    MODE_SLICE  = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef struct packed {
    logic       fst;
    logic       str;
    logic [2:0] cpc;
    logic [2:0] cpd;
    logic [1:0] mode;
    logic       decr;
    logic       dir;
  } chcr_t;

  typedef struct packed {
    op_t            op;
    logic [ChW-1:0] ch;
    logic [31:0]    data;
    logic           level;
  } dec_t;

  typedef struct packed {
    logic [31:0]    start_words;
    logic [23:0]    start_address;
    logic           start_decrement;
    logic           start_to_device;
    logic [1:0]     start_mode;
    logic [ChW-1:0] start_channel;
    logic           start_res;
    logic           irq;
    logic           error;
    logic [31:0]    read_data;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/dmac_decode.sv @@
// ---------------------------------------------------------------------------
// dmac_decode
// Turns one bus access or line event into an operation code and a channel.
// ---------------------------------------------------------------------------
`default_nettype none

module dmac_decode import dmac_pkg::*; (
  input  kind_t          kind,
  input  logic [31:0]    address,
  input  logic [31:0]    write_data,
  input  logic [ChW-1:0] channel,
  input  logic           drq_level,
  output dec_t           dec
);

  logic [7:0] sel;
  logic       ch_hit;
  logic       is_rd;

  assign sel    = address[11:4];
  assign ch_hit = (address[31:12] == DmaBase[31:12]) && (sel >= ChSelFirst) &&
                  (sel <= ChSelLast);
  assign is_rd  = (kind == KIND_READ);

  always_comb begin
    dec.op    = OP_ERR;
    dec.ch    = channel;
    dec.data  = write_data;
    dec.level = drq_level;
    if (kind == KIND_READ || kind == KIND_WRITE) begin
      dec.ch = address[6:4];
      priority if (ch_hit && address[3:0] == OffChcr) begin
        dec.op = is_rd ? OP_RD_CHCR : OP_WR_CHCR;
      end else if (ch_hit && !is_rd && address[3:0] == OffMadr) begin
        dec.op = OP_WR_MADR;
      end else if (ch_hit && !is_rd && address[3:0] == OffBcr) begin
        dec.op = OP_WR_BCR;
      end else if (address == DpcrAddr) begin
        dec.op = is_rd ? OP_RD_DPCR : OP_WR_DPCR;
      end else if (address == DicrAddr) begin
        dec.op = is_rd ? OP_RD_DICR : OP_WR_DICR;
      end else begin
        dec.op = OP_ERR;
      end
    end else if (channel < ChW'(NumCh)) begin
      dec.op = (kind == KIND_DRQ) ? OP_DRQ : OP_XFER_END;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dmac_core.sv @@
// ---------------------------------------------------------------------------
// dmac_core
// Channel, priority and interrupt registers with start and interrupt logic.
// ---------------------------------------------------------------------------
`default_nettype none

module dmac_core import dmac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  dec_t dec,
  output res_t res
);

  chcr_t             control_bits [NumCh];
  logic [23:0]       mem_address  [NumCh];
  logic [15:0]       block_size   [NumCh];
  logic [15:0]       block_count  [NumCh];
  logic [31:0]       slice_length [NumCh];
  logic [NumCh-1:0]  request_lines;
  logic [31:0]       priority_word;
  logic              irq_fi, irq_mie, irq_mif;
  logic [NumCh-1:0]  irq_im, irq_ip;

  chcr_t             cb_wr;
  chcr_t             cb_view [NumCh];
  logic [NumCh-1:0]  req_view;
  logic [31:0]       prio_view;
  logic [NumCh-1:0]  ready, cand, ch_oh;
  logic [ChW-1:0]    pe_ch, sel_ch;
  chcr_t             cb_sel;
  logic [23:0]       madr_sel;
  logic [15:0]       bsize_sel;
  logic [31:0]       slice_sel;
  logic              sup_sel, try_start, go;
  logic              fi_next, mie_next, mif_calc, mif_next, recalc;
  logic [NumCh-1:0]  im_next, ip_next;

  function automatic chcr_t chcr_from_bus(input logic [31:0] d);
    chcr_t c;
    c.dir  = d[0];
    c.decr = d[1];
    c.mode = d[10:9];
    c.cpd  = d[18:16];
    c.cpc  = d[22:20];
    c.str  = d[24];
    c.fst  = d[28];
    return c;
  endfunction

  function automatic logic [31:0] chcr_to_bus(input chcr_t c);
    logic [31:0] d;
    d        = '0;
    d[0]     = c.dir;
    d[1]     = c.decr;
    d[10:9]  = c.mode;
    d[18:16] = c.cpd;
    d[22:20] = c.cpc;
    d[24]    = c.str;
    d[28]    = c.fst;
    return d;
  endfunction

  assign cb_wr = chcr_from_bus(dec.data);
  assign ch_oh = NumCh'(1) << dec.ch;
  assign prio_view = (dec.op == OP_WR_DPCR) ? dec.data : priority_word;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      cb_view[i]  = (dec.op == OP_WR_CHCR && dec.ch == ChW'(i)) ? cb_wr : control_bits[i];
      req_view[i] = (dec.op == OP_DRQ && dec.ch == ChW'(i)) ? dec.level : request_lines[i];
      ready[i]    = (req_view[i] | cb_view[i].fst) & prio_view[4*i+3] & cb_view[i].str;
    end
  end

  always_comb begin
    unique case (dec.op)
      OP_WR_CHCR, OP_DRQ: cand = ready & ch_oh;
      OP_WR_DPCR:         cand = ready;
      default:            cand = '0;
    endcase
  end

  always_comb begin
    pe_ch = '0;
    for (int i = NumCh - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pe_ch = ChW'(i);
      end
    end
  end

  assign try_start = |cand;
  assign sel_ch    = try_start ? pe_ch : dec.ch;

  always_comb begin
    cb_sel    = '0;
    madr_sel  = '0;
    bsize_sel = '0;
    slice_sel = '0;
    sup_sel   = 1'b0;
    for (int i = 0; i < NumCh; i++) begin
      if (sel_ch == ChW'(i)) begin
        cb_sel    = cb_view[i];
        madr_sel  = mem_address[i];
        bsize_sel = block_size[i];
        slice_sel = slice_length[i];
        sup_sel   = SupportedCh[i];
      end
    end
  end

  assign go = try_start && sup_sel;

  always_comb begin
    fi_next  = irq_fi;
    im_next  = irq_im;
    mie_next = irq_mie;
    ip_next  = irq_ip;
    recalc   = 1'b0;
    unique case (dec.op)
      OP_WR_DICR: begin
        fi_next  = dec.data[15];
        im_next  = dec.data[22:16];
        mie_next = dec.data[23];
        ip_next  = irq_ip & ~dec.data[30:24];
        recalc   = 1'b1;
      end
      OP_XFER_END: begin
        ip_next = irq_ip | (irq_im & ch_oh);
        recalc  = 1'b1;
      end
      default: begin
      end
    endcase
    mif_calc = fi_next | (mie_next & (|(im_next & ip_next)));
    mif_next = recalc ? mif_calc : irq_mif;
  end

  always_comb begin
    res = '0;
    unique case (dec.op)
      OP_RD_CHCR: res.read_data = chcr_to_bus(cb_sel);
      OP_RD_DPCR: res.read_data = priority_word;
      OP_RD_DICR: res.read_data = {irq_mif, irq_ip, irq_mie, irq_im, irq_fi, 15'b0};
      default:    res.read_data = '0;
    endcase
    res.error = (dec.op == OP_ERR) || (try_start && !sup_sel);
    res.irq   = recalc && !irq_mif && mif_calc;
    if (go) begin
      res.start_res       = 1'b1;
      res.start_channel   = sel_ch;
      res.start_mode      = cb_sel.mode;
      res.start_to_device = cb_sel.dir;
      res.start_decrement = cb_sel.decr;
      res.start_address   = madr_sel;
      unique case (mode_t'(cb_sel.mode))
        MODE_SLICE: res.start_words = slice_sel;
        MODE_LIST:  res.start_words = '0;
        default:    res.start_words = {16'b0, bsize_sel};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCh; i++) begin
        control_bits[i] <= '0;
        mem_address[i]  <= '0;
        block_size[i]   <= '0;
        block_count[i]  <= '0;
        slice_length[i] <= '0;
      end
      request_lines <= 7'h55;
      priority_word <= '0;
      irq_fi        <= 1'b0;
      irq_im        <= '0;
      irq_mie       <= 1'b0;
      irq_ip        <= '0;
      irq_mif       <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < NumCh; i++) begin
        if (dec.op == OP_XFER_END && dec.ch == ChW'(i)) begin
          control_bits[i].str <= 1'b0;
        end else begin
          control_bits[i] <= cb_view[i];
        end
        if (dec.op == OP_WR_MADR && dec.ch == ChW'(i)) begin
          mem_address[i] <= dec.data[23:0] & AddrMask;
        end
        if (dec.op == OP_WR_BCR && dec.ch == ChW'(i)) begin
          block_size[i]   <= dec.data[15:0];
          block_count[i]  <= dec.data[31:16];
          slice_length[i] <= {16'b0, dec.data[31:16]} * {16'b0, dec.data[15:0]};
        end
        if (go && sel_ch == ChW'(i)) begin
          block_size[i]   <= '0;
          block_count[i]  <= '0;
          slice_length[i] <= '0;
        end
      end
      request_lines <= req_view;
      priority_word <= prio_view;
      irq_fi        <= fi_next;
      irq_im        <= im_next;
      irq_mie       <= mie_next;
      irq_ip        <= ip_next;
      irq_mif       <= mif_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dma_channel_register_and_start_control.sv @@
// ---------------------------------------------------------------------------
// dma_channel_register_and_start_control
// Register side of a seven-channel DMA controller: bus accesses, request
// lines and transfer ends in, one response with an optional start command out.
//
//   channel  dir  payload
//   s_axis   in   tuser: kind; tdata: address, write_data, channel, drq_level
//   m_axis   out  tdata: read data, error, irq, start command
//
// One request per cycle while m_axis_tready holds; each passes from acceptance
// through the input register and then the response register to the response.
// Register state updates as a request leaves the input register.
// A stalled response holds the input register; s_axis_tready follows
// m_axis_tready through that chain. Reset is synchronous.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dma_channel_register_and_start_control import dmac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // address[31:0], write_data[63:32], channel[66:64], drq_level[67], zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // read_data[31:0], error[32], irq[33], start_res[34], start_channel[37:35],
  // start_mode[39:38], start_to_device[40], start_decrement[41],
  // start_address[65:42], start_words[97:66], zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic           in_valid;
  kind_t          in_kind;
  logic [31:0]    in_address;
  logic [31:0]    in_write_data;
  logic [ChW-1:0] in_channel;
  logic           in_level;
  logic           out_valid;
  res_t           res, res_q;
  dec_t           dec;
  logic           load_out, fire;
  logic           out_cmd, cmd_ch_ok, cmd_zero;

  assign load_out      = !out_valid || m_axis_tready;
  assign fire          = in_valid && load_out;
  assign s_axis_tready = !in_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind       <= kind_t'(s_axis_tuser);
      in_address    <= s_axis_tdata[31:0];
      in_write_data <= s_axis_tdata[63:32];
      in_channel    <= s_axis_tdata[66:64];
      in_level      <= s_axis_tdata[67];
    end
  end

  dmac_decode u_decode (
    .kind       (in_kind),
    .address    (in_address),
    .write_data (in_write_data),
    .channel    (in_channel),
    .drq_level  (in_level),
    .dec        (dec)
  );

  dmac_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .dec  (dec),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OutTdataW - $bits(res_t))'(0), res_q};

  assign out_cmd   = out_valid && res_q.start_res;
  assign cmd_ch_ok = SupportedCh[res_q.start_channel];
  assign cmd_zero  = (res_q.start_words == 32'd0) && (res_q.start_address == 24'd0);

  `ASSERT_CLK(a_no_fire_on_stall, out_valid && !m_axis_tready |-> !fire, "response overrun")
  `ASSERT_CLK(a_start_no_error, out_cmd |-> !res_q.error, "start issued with error")
  `ASSERT_CLK(a_start_supported, out_cmd |-> cmd_ch_ok, "unsupported channel started")
  `ASSERT_CLK(a_idle_cmd_zero, out_valid && !out_cmd |-> cmd_zero, "command without start")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !in_valid && !out_valid, "not empty after reset")

endmodule

`default_nettype wire
